// File: rtl/core/gcvs_pkg.sv
// Package for the GC victim group selector: sizes, operation codes, request and
// response structs, sequencer states. No dependencies.
package gcvs_pkg;

   localparam int BAND_COUNT = 64;
   localparam int BANDS_PER_GROUP = 4;
   localparam int BAND_W = $clog2(BAND_COUNT);
   localparam int GRP_W = (BAND_COUNT > BANDS_PER_GROUP) ?
      $clog2((BAND_COUNT + BANDS_PER_GROUP - 1) / BANDS_PER_GROUP) : 1;
   localparam int LAST_GROUP = (BAND_COUNT - 1) / BANDS_PER_GROUP;
   localparam int WSUM_W = 32 + $clog2(BANDS_PER_GROUP + 1);
   localparam int ISUM_W = 24 + $clog2(BANDS_PER_GROUP + 1);
   localparam int CSR_W = 28;
   localparam int CSR_IDX_W = 1;

   localparam logic [CSR_IDX_W-1:0] CSR_BLOCKS = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_THRESH = 1'd1;

   typedef enum logic [1:0] {
      OP_UPDATE = 2'd0,
      OP_SET_PRIO = 2'd1,
      OP_REQUEST = 2'd2,
      OP_RESET_ITER = 2'd3
   } op_type;

   typedef struct packed {
      logic [1:0] operation;
      logic [5:0] band_index;
      logic band_closed;
      logic band_relocating;
      logic [31:0] band_write_count;
      logic [23:0] band_valid_blocks;
   } req_type;

   typedef struct packed {
      logic victim_found;
      logic [5:0] victim_band;
      logic from_high_priority;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ITER,
      ST_SCORE,
      ST_PICK,
      ST_DONE
   } state_type;

endpackage

// File: rtl/core/gc_victim_group_selector.sv
// GC victim group selector top level: band table, sequencer and one shared
// accumulate/compare unit. Depends on gcvs_pkg.
// A request is served from a pending priority band, else by walking the iterator's
// group, else by scoring all groups (one band per cycle, a pick step after each
// group) and then walking the best group. One request at a time; busy
// is high until rsp_valid. Sync reset clears valid bits and control state at once.
module gc_victim_group_selector (
   input  logic clock,
   input  logic reset,
   input  logic start,
   output logic busy,
   input  gcvs_pkg::req_type req_data,
   output logic rsp_valid,
   output gcvs_pkg::rsp_type rsp_data,
   input  logic csr_we,
   input  logic [gcvs_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [gcvs_pkg::CSR_W-1:0] csr_wdata
);
   import gcvs_pkg::*;

   logic [BAND_COUNT-1:0] closed_ff, closed_in, reloc_ff, reloc_in;
   logic [BAND_COUNT-1:0] wrote_ff, wrote_in;
   logic [31:0] wcnt_mem [BAND_COUNT];
   logic [23:0] vcnt_mem [BAND_COUNT];
   logic [31:0] wcnt_rd_ff;
   logic [23:0] vcnt_rd_ff;
   logic hit_rd_ff;
   logic [23:0] blocks_ff;
   logic [27:0] thresh_ff;
   logic prio_pend_ff, prio_pend_in;
   logic [BAND_W-1:0] prio_band_ff, prio_band_in;
   logic iter_act_ff, iter_act_in;
   logic [BAND_W:0] iter_band_ff, iter_band_in;
   logic [GRP_W-1:0] iter_grp_ff, iter_grp_in;
   state_type state_ff, state_in;
   logic [BAND_W:0] scan_ff, scan_in;
   logic [ISUM_W-1:0] inv_ff, inv_in, max_inv_ff, max_inv_in;
   logic [WSUM_W-1:0] wr_ff, wr_in, max_wr_ff, max_wr_in;
   logic [GRP_W-1:0] best_ff, best_in;
   logic have_ff, have_in;
   rsp_type rsp_ff, rsp_in;
   logic rsp_valid_ff, rsp_valid_in;

   logic [BAND_W-1:0] sb, ib, rd_addr, wr_addr;
   logic s_move, i_move, grp_end, better, iter_in_grp, mem_we;
   logic [ISUM_W-1:0] inv_add, diff;
   logic [31:0] band_wcnt;
   logic [23:0] band_vcnt;

   assign sb = scan_ff[BAND_W-1:0];
   assign ib = iter_band_ff[BAND_W-1:0];
   assign rd_addr = scan_in[BAND_W-1:0];
   assign wr_addr = req_data.band_index[BAND_W-1:0];
   assign mem_we = (state_ff == ST_IDLE) && start && req_data.operation == OP_UPDATE &&
      32'(req_data.band_index) < BAND_COUNT;
   assign band_wcnt = hit_rd_ff ? wcnt_rd_ff : '0;
   assign band_vcnt = hit_rd_ff ? vcnt_rd_ff : '0;
   assign s_move = closed_ff[sb] && !reloc_ff[sb];
   assign i_move = closed_ff[ib] && !reloc_ff[ib];
   assign iter_in_grp = (iter_band_ff < (BAND_W+1)'(BAND_COUNT)) &&
      (GRP_W'(iter_band_ff / BANDS_PER_GROUP) == iter_grp_ff);
   assign inv_add = (s_move && blocks_ff > band_vcnt) ?
      ISUM_W'(blocks_ff - band_vcnt) : '0;
   assign grp_end = (scan_ff == (BAND_W+1)'(BAND_COUNT - 1)) ||
      ((scan_ff % BANDS_PER_GROUP) == (BAND_W+1)'(BANDS_PER_GROUP - 1));
   assign diff = (inv_ff > max_inv_ff) ? inv_ff - max_inv_ff : max_inv_ff - inv_ff;
   assign better = (CSR_W'(diff) > thresh_ff) ? (inv_ff > max_inv_ff) :
      (wr_ff != max_wr_ff) ? (wr_ff < max_wr_ff) : 1'b0;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (start) begin
            state_in = ST_DONE;
            if (req_data.operation == OP_REQUEST && !prio_pend_ff) begin
               state_in = iter_act_ff ? ST_ITER : ST_SCORE;
            end
         end
         ST_ITER: if (!iter_in_grp) begin
            state_in = have_ff ? ST_DONE : ST_SCORE;
         end else if (i_move) begin
            state_in = ST_DONE;
         end
         ST_SCORE: if (grp_end) state_in = ST_PICK;
         ST_PICK: state_in = (scan_ff == (BAND_W+1)'(BAND_COUNT)) ?
            (have_ff || (inv_ff != '0) ? ST_ITER : ST_DONE) : ST_SCORE;
         ST_DONE: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      closed_in = closed_ff;
      reloc_in = reloc_ff;
      wrote_in = wrote_ff;
      prio_pend_in = prio_pend_ff;
      prio_band_in = prio_band_ff;
      iter_act_in = iter_act_ff;
      iter_band_in = iter_band_ff;
      iter_grp_in = iter_grp_ff;
      scan_in = scan_ff;
      inv_in = inv_ff;
      wr_in = wr_ff;
      max_inv_in = max_inv_ff;
      max_wr_in = max_wr_ff;
      best_in = best_ff;
      have_in = have_ff;
      rsp_in = rsp_ff;
      rsp_valid_in = 1'b0;
      unique case (state_ff)
         ST_IDLE: if (start) begin
            rsp_in = '0;
            scan_in = '0;
            inv_in = '0;
            wr_in = '0;
            max_inv_in = '0;
            max_wr_in = '0;
            best_in = '0;
            have_in = 1'b0;
            unique case (op_type'(req_data.operation))
               OP_UPDATE: if (32'(req_data.band_index) < BAND_COUNT) begin
                  closed_in[wr_addr] = req_data.band_closed;
                  reloc_in[wr_addr] = req_data.band_relocating;
                  wrote_in[wr_addr] = 1'b1;
               end
               OP_SET_PRIO: if (32'(req_data.band_index) < BAND_COUNT) begin
                  prio_band_in = req_data.band_index[BAND_W-1:0];
                  prio_pend_in = 1'b1;
               end
               OP_RESET_ITER: begin
                  iter_act_in = 1'b0;
                  prio_pend_in = 1'b0;
               end
               OP_REQUEST: begin
                  prio_pend_in = 1'b0;
                  if (prio_pend_ff) begin
                     reloc_in[prio_band_ff] = 1'b1;
                     rsp_in.victim_found = 1'b1;
                     rsp_in.victim_band = 6'(prio_band_ff);
                     rsp_in.from_high_priority = 1'b1;
                  end
               end
               default: ;
            endcase
         end
         ST_ITER: if (iter_in_grp) begin
            if (i_move) begin
               reloc_in[ib] = 1'b1;
               rsp_in.victim_found = 1'b1;
               rsp_in.victim_band = 6'(ib);
            end else begin
               iter_band_in = iter_band_ff + 1'b1;
            end
         end
         ST_SCORE: begin
            inv_in = inv_ff + inv_add;
            wr_in = wr_ff + WSUM_W'(band_wcnt);
            scan_in = scan_ff + 1'b1;
         end
         ST_PICK: begin
            if (inv_ff != '0 && (!have_ff || better)) begin
               max_wr_in = wr_ff;
               best_in = GRP_W'((scan_ff - 1'b1) / BANDS_PER_GROUP);
               have_in = 1'b1;
               if (inv_ff > max_inv_ff) max_inv_in = inv_ff;
            end
            inv_in = '0;
            wr_in = '0;
            if (scan_ff == (BAND_W+1)'(BAND_COUNT)) begin
               if (inv_ff != '0 && (!have_ff || better)) begin
                  iter_grp_in = GRP_W'((scan_ff - 1'b1) / BANDS_PER_GROUP);
                  iter_band_in = (BAND_W+1)'(((scan_ff - 1'b1) / BANDS_PER_GROUP)
                     * BANDS_PER_GROUP);
                  iter_act_in = 1'b1;
               end else if (have_ff) begin
                  iter_grp_in = best_ff;
                  iter_band_in = (BAND_W+1)'(best_ff * BANDS_PER_GROUP);
                  iter_act_in = 1'b1;
               end else begin
                  iter_act_in = 1'b0;
               end
            end
         end
         ST_DONE: rsp_valid_in = 1'b1;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         closed_ff <= '0;
         reloc_ff <= '0;
         wrote_ff <= '0;
         prio_pend_ff <= 1'b0;
         prio_band_ff <= '0;
         iter_act_ff <= 1'b0;
         iter_band_ff <= '0;
         iter_grp_ff <= '0;
         rsp_valid_ff <= 1'b0;
         blocks_ff <= 24'd262144;
         thresh_ff <= 28'd104857;
      end else begin
         state_ff <= state_in;
         closed_ff <= closed_in;
         reloc_ff <= reloc_in;
         wrote_ff <= wrote_in;
         prio_pend_ff <= prio_pend_in;
         prio_band_ff <= prio_band_in;
         iter_act_ff <= iter_act_in;
         iter_band_ff <= iter_band_in;
         iter_grp_ff <= iter_grp_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we && csr_index == CSR_BLOCKS) blocks_ff <= csr_wdata[23:0];
         if (csr_we && csr_index == CSR_THRESH) thresh_ff <= csr_wdata;
      end
   end

   // band record store, read address is the next scan pointer value so the registered read lines up with scan_ff
   always_ff @(posedge clock) begin
      if (mem_we) begin
         wcnt_mem[wr_addr] <= req_data.band_write_count;
         vcnt_mem[wr_addr] <= req_data.band_valid_blocks;
      end
      wcnt_rd_ff <= wcnt_mem[rd_addr];
      vcnt_rd_ff <= vcnt_mem[rd_addr];
      hit_rd_ff <= wrote_ff[rd_addr];
   end

   always_ff @(posedge clock) begin
      scan_ff <= scan_in;
      inv_ff <= inv_in;
      wr_ff <= wr_in;
      max_inv_ff <= max_inv_in;
      max_wr_ff <= max_wr_in;
      best_ff <= best_in;
      have_ff <= have_in;
      rsp_ff <= rsp_in;
   end

   assign busy = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_valid_ff ? rsp_ff : '0;

`ifndef SYNTHESIS
   a_rsp_after_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(state_ff) == ST_DONE) else $error("rsp without done");
   a_idle_after_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> state_ff == ST_IDLE) else $error("busy during rsp");
   a_found_band: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.victim_found |-> reloc_ff[rsp_data.victim_band[BAND_W-1:0]])
      else $error("victim not marked");
   a_prio_found: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.from_high_priority |-> rsp_data.victim_found)
      else $error("prio without found");
`endif
endmodule

// File: dv/tb.sv
// Testbench for gc_victim_group_selector: queue-fed request driver, strobe monitor
// and an in-bench predictor of the band table and victim choice. Depends on gcvs_pkg.
module tb;
   import gcvs_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   req_type req_data = '0;
   logic rsp_valid;
   rsp_type rsp_data;
   logic csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_W-1:0] csr_wdata = '0;

   gc_victim_group_selector i_dut (.*);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // predictor state
   bit closed_q[BAND_COUNT];
   bit moving_q[BAND_COUNT];
   bit [31:0] writes_q[BAND_COUNT];
   bit [23:0] valid_q[BAND_COUNT];
   bit prio_pend;
   bit [5:0] prio_band;
   bit iter_on;
   int iter_band;
   int iter_grp;
   bit [23:0] blocks_cfg = 24'd262144;
   bit [27:0] thresh_cfg = 28'd104857;

   req_type pending_q[$];
   rsp_type victims_q[$];
   int errors = 0;
   int send_idle = 18;
   bit draining = 1'b0;

   function automatic bit movable(int b);
      return closed_q[b] && !moving_q[b];
   endfunction

   function automatic bit walk_group(output int v);
      v = 0;
      if (!iter_on) return 0;
      while (iter_band < BAND_COUNT && iter_band / BANDS_PER_GROUP == iter_grp) begin
         if (movable(iter_band)) begin
            moving_q[iter_band] = 1'b1;
            v = iter_band;
            return 1;
         end
         iter_band++;
      end
      return 0;
   endfunction

   function automatic rsp_type pick_victim(req_type r);
      rsp_type o;
      int v;
      bit hit;
      longint unsigned inv, wr, max_inv, max_wr, diff;
      int best;
      bit have, better;
      o = '0;
      v = 0;
      hit = 0;
      case (op_type'(r.operation))
         OP_UPDATE: begin
            closed_q[r.band_index] = r.band_closed;
            moving_q[r.band_index] = r.band_relocating;
            writes_q[r.band_index] = r.band_write_count;
            valid_q[r.band_index] = r.band_valid_blocks;
         end
         OP_SET_PRIO: begin
            prio_band = r.band_index;
            prio_pend = 1'b1;
         end
         OP_RESET_ITER: begin
            iter_on = 1'b0;
            prio_pend = 1'b0;
         end
         default: begin
            if (prio_pend) begin
               prio_pend = 1'b0;
               moving_q[prio_band] = 1'b1;
               o.victim_found = 1'b1;
               o.victim_band = prio_band;
               o.from_high_priority = 1'b1;
               return o;
            end
            hit = walk_group(v);
            if (!hit) begin
               max_inv = 0;
               max_wr = 0;
               best = 0;
               have = 0;
               for (int g = 0; g <= LAST_GROUP; g++) begin
                  inv = 0;
                  wr = 0;
                  for (int b = g * BANDS_PER_GROUP;
                       b < BAND_COUNT && b / BANDS_PER_GROUP == g; b++) begin
                     wr += writes_q[b];
                     if (movable(b) && blocks_cfg > valid_q[b])
                        inv += blocks_cfg - valid_q[b];
                  end
                  if (inv == 0) continue;
                  diff = inv > max_inv ? inv - max_inv : max_inv - inv;
                  if (diff > thresh_cfg) better = inv > max_inv;
                  else if (wr != max_wr) better = wr < max_wr;
                  else better = g < best;
                  if (!have || better) begin
                     max_wr = wr;
                     best = g;
                     have = 1;
                     if (inv > max_inv) max_inv = inv;
                  end
               end
               if (have) begin
                  iter_band = best * BANDS_PER_GROUP;
                  iter_grp = best;
                  iter_on = 1'b1;
                  hit = walk_group(v);
               end else begin
                  iter_on = 1'b0;
               end
            end
            o.victim_found = hit;
            o.victim_band = hit ? 6'(v) : 6'd0;
         end
      endcase
      return o;
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (start && busy) begin
         // request still waiting for acceptance
      end else if (pending_q.size() > 0 && $urandom_range(99) >= send_idle) begin
         req_data <= pending_q[0];
         victims_q.push_back(pick_victim(pending_q.pop_front()));
         start <= 1'b1;
      end else begin
         start <= 1'b0;
         if (draining) req_data <= '0;
      end
   end

   // monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (victims_q.size() == 0) begin
            $display("%0t unexpected response %p", $time, rsp_data);
            errors++;
         end else begin
            rsp_type e;
            e = victims_q.pop_front();
            if (e.victim_found !== rsp_data.victim_found ||
                e.victim_band !== rsp_data.victim_band ||
                e.from_high_priority !== rsp_data.from_high_priority) begin
               $display("%0t mismatch expected %p actual %p", $time, e, rsp_data);
               errors++;
            end
         end
      end
   end

   function automatic req_type make_req(op_type op, int b);
      req_type r;
      r = '0;
      r.operation = op;
      r.band_index = 6'(b);
      return r;
   endfunction

   function automatic req_type rand_update(int b, int mode);
      req_type r;
      r = make_req(OP_UPDATE, b);
      r.band_closed = ($urandom_range(9) < 8);
      r.band_relocating = ($urandom_range(9) < 2);
      r.band_write_count = mode == 0 ? 32'($urandom_range(1000)) : $urandom;
      case ($urandom_range(3))
         0: r.band_valid_blocks = 24'($urandom);
         1: r.band_valid_blocks = 24'($urandom_range(blocks_cfg + 2));
         default: r.band_valid_blocks = 24'($urandom_range(600));
      endcase
      return r;
   endfunction

   task automatic wait_empty();
      while (pending_q.size() > 0 || victims_q.size() > 0 || start) @(posedge clock);
      repeat (BAND_COUNT + 2 * BANDS_PER_GROUP + 8) @(posedge clock);
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, int unsigned val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= CSR_W'(val);
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_BLOCKS) blocks_cfg = 24'(val);
      else thresh_cfg = 28'(val);
   endtask

   task automatic random_phase(int n);
      int k, r;
      k = 0;
      while (k < n) begin
         r = $urandom_range(99);
         if (r < 45) pending_q.push_back(rand_update($urandom_range(63), $urandom_range(1)));
         else if (r < 55) pending_q.push_back(make_req(OP_SET_PRIO, $urandom_range(63)));
         else if (r < 93) pending_q.push_back(make_req(OP_REQUEST, $urandom_range(63)));
         else pending_q.push_back(make_req(OP_RESET_ITER, $urandom_range(63)));
         k++;
      end
      wait_empty();
   endtask

   initial begin
      req_type r;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // directed: empty table, extremes, priority on a non-movable band, saturation
      pending_q.push_back(make_req(OP_REQUEST, 0));
      r = make_req(OP_UPDATE, 63);
      r.band_closed = 1;
      r.band_write_count = '1;
      r.band_valid_blocks = 24'hFFFFFF;
      pending_q.push_back(r);
      pending_q.push_back(make_req(OP_REQUEST, 0));
      r = make_req(OP_UPDATE, 0);
      r.band_closed = 1;
      r.band_valid_blocks = 24'd5;
      pending_q.push_back(r);
      r.band_index = 6'd1;
      r.band_relocating = 1;
      pending_q.push_back(r);
      r = make_req(OP_UPDATE, 2);
      r.band_closed = 1;
      pending_q.push_back(r);
      pending_q.push_back(make_req(OP_SET_PRIO, 40));
      pending_q.push_back(make_req(OP_REQUEST, 0));
      pending_q.push_back(make_req(OP_REQUEST, 0));
      pending_q.push_back(make_req(OP_REQUEST, 0));
      pending_q.push_back(make_req(OP_SET_PRIO, 63));
      pending_q.push_back(make_req(OP_RESET_ITER, 0));
      pending_q.push_back(make_req(OP_REQUEST, 0));
      pending_q.push_back(make_req(OP_REQUEST, 0));
      wait_empty();
      write_csr(CSR_BLOCKS, 0);
      write_csr(CSR_THRESH, 0);
      random_phase(120);
      write_csr(CSR_BLOCKS, 24'hFFFFFF);
      write_csr(CSR_THRESH, 28'hFFFFFFF);
      random_phase(200);
      write_csr(CSR_BLOCKS, 1);
      write_csr(CSR_THRESH, 0);
      random_phase(200);
      send_idle = 87;
      write_csr(CSR_BLOCKS, 1000);
      write_csr(CSR_THRESH, 150);
      random_phase(300);
      send_idle = 0;
      write_csr(CSR_BLOCKS, 600);
      write_csr(CSR_THRESH, 40);
      random_phase(300);
      write_csr(CSR_BLOCKS, $urandom_range(24'hFFFFFF, 1));
      write_csr(CSR_THRESH, $urandom_range(28'hFFFFFFF));
      draining = 1'b1;
      random_phase(320);
      if (errors == 0)
         $display("tb: clean");
      else
         $display("tb: errors");
      $finish;
   end

   initial begin
      #9000000;
      $display("tb: errors");
      $finish;
   end
endmodule
